// File: sv/strt_pkg.sv
// ----------------------------------------------------------------------------
// strt_pkg
// Shared types and constants for the space-time reservation table.
// ----------------------------------------------------------------------------
package strt_pkg;

	localparam int TIME_W      = 16;
	localparam int LOC_IN_W    = 32;
	localparam int AGENT_W     = 8;
	localparam int CMD_W       = 2;
	localparam int IN_TDATA_W  = 64;
	localparam int OUT_TDATA_W = 8;

	// command codes; code 3 is unused, leaves the table unchanged and returns an all-zero result
	typedef enum logic [CMD_W-1:0] {
		CMD_RESERVE = 2'd0,
		CMD_QUERY   = 2'd1,
		CMD_UPDATE  = 2'd2
	} cmd_e;

	// controller -> datapath
	typedef struct packed {
		logic accept;   // input word taken this cycle
		logic scan;     // walking the table
		logic finish;   // commit result and table write
	} ctl_t;

	// datapath -> controller
	typedef struct packed {
		logic needs_scan;  // incoming command is query or update
		logic empty;       // no slot in use
		logic hit;         // slot in read stage matches
		logic last;        // slot in read stage is the last one in use
		logic out_free;    // output register can take a word
	} sts_t;

endpackage

// File: sv/strt_ctrl.sv
// ----------------------------------------------------------------------------
// strt_ctrl
// Command sequencer: accept, table walk, result commit.
// ----------------------------------------------------------------------------
module strt_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            s_tvalid,
	output logic            s_tready,
	input  strt_pkg::sts_t  sts,
	output strt_pkg::ctl_t  ctl
);
	import strt_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE   = 3'b001,
		ST_SCAN   = 3'b010,
		ST_FINISH = 3'b100
	} state_t;

	state_t state_q, state_d;

	assign s_tready   = (state_q == ST_IDLE);
	assign ctl.accept = s_tvalid && s_tready;
	assign ctl.scan   = (state_q == ST_SCAN);
	assign ctl.finish = (state_q == ST_FINISH) && sts.out_free;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (s_tvalid) begin
					state_d = (sts.needs_scan && !sts.empty) ? ST_SCAN : ST_FINISH;
				end
			end
			ST_SCAN: begin
				if (sts.hit || sts.last) begin
					state_d = ST_FINISH;
				end
			end
			ST_FINISH: begin
				if (sts.out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

// File: sv/strt_dp.sv
// ----------------------------------------------------------------------------
// strt_dp
// Reservation store, command registers, one-slot-per-cycle match stage and
// output register.
// ----------------------------------------------------------------------------
module strt_dp #(
	parameter int TABLE_ENTRIES = 64,
	parameter int LOCATION_BITS = 32
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic [strt_pkg::IN_TDATA_W-1:0]    s_tdata,
	output logic                               m_tvalid,
	input  logic                               m_tready,
	output logic [strt_pkg::OUT_TDATA_W-1:0]   m_tdata,
	input  strt_pkg::ctl_t                     ctl,
	output strt_pkg::sts_t                     sts
);
	import strt_pkg::*;

	localparam int IW = $clog2(TABLE_ENTRIES);
	localparam int CW = $clog2(TABLE_ENTRIES + 1);
	localparam int LW = (LOCATION_BITS < LOC_IN_W) ? LOCATION_BITS : LOC_IN_W;

	typedef struct packed {
		logic [TIME_W-1:0]        tstep;
		logic [LOCATION_BITS-1:0] loc;
		logic [AGENT_W-1:0]       agent;
	} entry_t;

	entry_t mem [TABLE_ENTRIES];

	// unpacked input word
	logic [CMD_W-1:0]         in_cmd;
	logic [TIME_W-1:0]        in_time;
	logic [LOC_IN_W-1:0]      in_loc;
	logic [AGENT_W-1:0]       in_agent;
	logic [LOCATION_BITS-1:0] in_loc_m;

	assign in_cmd   = s_tdata[CMD_W-1:0];
	assign in_time  = s_tdata[CMD_W+TIME_W-1:CMD_W];
	assign in_loc   = s_tdata[CMD_W+TIME_W+LOC_IN_W-1:CMD_W+TIME_W];
	assign in_agent = s_tdata[CMD_W+TIME_W+LOC_IN_W+AGENT_W-1:CMD_W+TIME_W+LOC_IN_W];

	always_comb begin
		in_loc_m = '0;
		in_loc_m[LW-1:0] = in_loc[LW-1:0];
	end

	logic [CMD_W-1:0]         cmd_q;
	logic [TIME_W-1:0]        time_q;
	logic [LOCATION_BITS-1:0] loc_q;
	logic [AGENT_W-1:0]       agent_q;
	logic [CW-1:0]            fill_q;
	logic [CW-1:0]            addr_q;
	logic                     rd_vld_s1;
	logic [IW-1:0]            idx_s1;
	entry_t                   rd_s1;
	logic                     hit_q;
	logic [IW-1:0]            hit_idx_q;
	logic                     m_tvalid_q;
	logic [OUT_TDATA_W-1:0]   m_tdata_q;

	logic is_reserve, is_query, is_update;
	logic full, issue, hit_s1, last_s1, wr_en;
	logic [IW-1:0] wr_idx;

	assign is_reserve = (cmd_q == CMD_RESERVE);
	assign is_query   = (cmd_q == CMD_QUERY);
	assign is_update  = (cmd_q == CMD_UPDATE);
	assign full       = (fill_q == CW'(TABLE_ENTRIES));
	assign issue      = ctl.scan && (addr_q < fill_q);

	always_comb begin
		hit_s1 = 1'b0;
		if (rd_vld_s1 && rd_s1.tstep == time_q) begin
			if (is_query) begin
				hit_s1 = (rd_s1.loc == loc_q) && (rd_s1.agent != agent_q);
			end else if (is_update) begin
				hit_s1 = (rd_s1.agent == agent_q);
			end
		end
	end

	assign last_s1 = rd_vld_s1 && ((CW'(idx_s1) + CW'(1)) == fill_q);

	// an update rewrites the matched slot; time and agent equal the command's
	assign wr_en  = ctl.finish && ((is_reserve && !full) || (is_update && hit_q));
	assign wr_idx = is_reserve ? fill_q[IW-1:0] : hit_idx_q;

	always_ff @(posedge clk) begin
		if (issue) begin
			rd_s1  <= mem[addr_q[IW-1:0]];
			idx_s1 <= addr_q[IW-1:0];
		end
		if (wr_en) begin
			mem[wr_idx] <= '{tstep: time_q, loc: loc_q, agent: agent_q};
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.accept) begin
			cmd_q   <= in_cmd;
			time_q  <= in_time;
			loc_q   <= in_loc_m;
			agent_q <= in_agent;
		end
		if (ctl.scan && hit_s1) begin
			hit_idx_q <= idx_s1;
		end
		if (ctl.finish) begin
			m_tdata_q <= {{(OUT_TDATA_W-3){1'b0}},
			              is_reserve && full,
			              is_update && hit_q,
			              is_query && hit_q};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q     <= '0;
			addr_q     <= '0;
			rd_vld_s1  <= 1'b0;
			hit_q      <= 1'b0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (ctl.accept) begin
				addr_q    <= '0;
				rd_vld_s1 <= 1'b0;
				hit_q     <= 1'b0;
			end else begin
				rd_vld_s1 <= issue;
				if (issue) begin
					addr_q <= addr_q + CW'(1);
				end
				if (ctl.scan && hit_s1) begin
					hit_q <= 1'b1;
				end
			end
			if (ctl.finish && is_reserve && !full) begin
				fill_q <= fill_q + CW'(1);
			end
			if (ctl.finish) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	assign m_tvalid       = m_tvalid_q;
	assign m_tdata        = m_tdata_q;
	assign sts.needs_scan = (in_cmd == CMD_QUERY) || (in_cmd == CMD_UPDATE);
	assign sts.empty      = (fill_q == '0);
	assign sts.hit        = hit_s1;
	assign sts.last       = last_s1;
	assign sts.out_free   = !m_tvalid_q || m_tready;

endmodule

// File: sv/space_time_reservation_table_core.sv
// ----------------------------------------------------------------------------
// space_time_reservation_table_core
// Space-time reservation table with reserve, query and update commands.
// ----------------------------------------------------------------------------
// Reservations (time step, location, agent) are appended in arrival order to
// a single-port-read RAM of TABLE_ENTRIES slots and are never freed. One
// command word is handled at a time. Reserve and the unused command code skip
// the table walk. Query and update walk the slots in use one per cycle
// through the RAM read port and stop at the first match or after the last
// slot in use; on an empty table they skip the walk. The result sits in an
// output register; a new command is taken while it waits.
module space_time_reservation_table_core #(
	parameter int TABLE_ENTRIES = 64,
	parameter int LOCATION_BITS = 32
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	// [1:0] command, [17:2] time_step, [49:18] location, [57:50] agent_id
	input  logic [strt_pkg::IN_TDATA_W-1:0]   s_tdata,
	output logic                              m_tvalid,
	input  logic                              m_tready,
	// [0] reserved_by_other, [1] entry_found, [2] table_full
	output logic [strt_pkg::OUT_TDATA_W-1:0]  m_tdata
);
	import strt_pkg::*;

	ctl_t ctl;
	sts_t sts;

	strt_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.sts      (sts),
		.ctl      (ctl)
	);

	strt_dp #(
		.TABLE_ENTRIES (TABLE_ENTRIES),
		.LOCATION_BITS (LOCATION_BITS)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.ctl      (ctl),
		.sts      (sts)
	);

endmodule

// File: tb/reservation_checker.sv
// ----------------------------------------------------------------------------
// reservation_checker
// Watches both stream ports of the reservation table, keeps its own copy of
// the table, and compares every result word with the predicted outcome.
// ----------------------------------------------------------------------------
module reservation_checker #(
	parameter int TABLE_SLOTS = 64
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               s_tvalid,
	input  logic                               s_tready,
	// [1:0] command, [17:2] time_step, [49:18] location, [57:50] agent_id
	input  logic [strt_pkg::IN_TDATA_W-1:0]    s_tdata,
	input  logic                               m_tvalid,
	input  logic                               m_tready,
	// [0] reserved_by_other, [1] entry_found, [2] table_full
	input  logic [strt_pkg::OUT_TDATA_W-1:0]   m_tdata,
	output int                                 fail_count,
	output int                                 outstanding
);
	import strt_pkg::*;

	typedef struct packed {
		logic other;
		logic found;
		logic full;
	} outcome_t;

	outcome_t due_outcomes[$];
	outcome_t due;

	logic                held_valid [TABLE_SLOTS];
	logic [TIME_W-1:0]   held_time  [TABLE_SLOTS];
	logic [LOC_IN_W-1:0] held_loc   [TABLE_SLOTS];
	logic [AGENT_W-1:0]  held_agent [TABLE_SLOTS];
	int                  held_count;

	// applies one command word to the shadow table and returns its outcome
	function automatic outcome_t apply_command(input logic [CMD_W-1:0] cmd,
			input logic [TIME_W-1:0] t, input logic [LOC_IN_W-1:0] loc,
			input logic [AGENT_W-1:0] who);
		outcome_t o;
		int       i;
		logic     done;
		o = '0;
		done = 1'b0;
		if (cmd == CMD_RESERVE) begin
			if (held_count < TABLE_SLOTS) begin
				held_valid[held_count] = 1'b1;
				held_time[held_count]  = t;
				held_loc[held_count]   = loc;
				held_agent[held_count] = who;
				held_count++;
			end else begin
				o.full = 1'b1;
			end
		end else if (cmd == CMD_QUERY) begin
			for (i = 0; i < TABLE_SLOTS && !done; i++) begin
				if (held_valid[i] && held_time[i] == t && held_loc[i] == loc &&
						held_agent[i] != who) begin
					o.other = 1'b1;
					done = 1'b1;
				end
			end
		end else if (cmd == CMD_UPDATE) begin
			// earliest-inserted match only
			for (i = 0; i < TABLE_SLOTS && !done; i++) begin
				if (held_valid[i] && held_time[i] == t && held_agent[i] == who) begin
					held_loc[i] = loc;
					o.found = 1'b1;
					done = 1'b1;
				end
			end
		end
		return o;
	endfunction

	task automatic compare_field(input string field, input logic [4:0] want,
			input logic [4:0] got);
		if (want !== got) begin
			$display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
			fail_count++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < TABLE_SLOTS; i++)
				held_valid[i] = 1'b0;
			held_count = 0;
			fail_count = 0;
			due_outcomes.delete();
			outstanding <= 0;
		end else begin
			// result first: a word leaving now belongs to an earlier command
			if (m_tvalid && m_tready) begin
				if (due_outcomes.size() == 0) begin
					$display("%0t: result word %h with nothing expected", $time, m_tdata);
					fail_count++;
				end else begin
					due = due_outcomes.pop_front();
					compare_field("reserved_by_other", {4'd0, due.other}, {4'd0, m_tdata[0]});
					compare_field("entry_found", {4'd0, due.found}, {4'd0, m_tdata[1]});
					compare_field("table_full", {4'd0, due.full}, {4'd0, m_tdata[2]});
					compare_field("pad bits", 5'd0, m_tdata[7:3]);
				end
			end
			if (s_tvalid && s_tready)
				due_outcomes.insert(due_outcomes.size(), apply_command(s_tdata[1:0],
					s_tdata[17:2], s_tdata[49:18], s_tdata[57:50]));
			outstanding <= due_outcomes.size();
		end
	end

endmodule

// File: tb/space_time_reservation_table_core_tb.sv
// ----------------------------------------------------------------------------
// space_time_reservation_table_core_tb
// Directed and random reserve/query/update traffic with bursty input and a
// stalling output side; results are checked by reservation_checker.
// ----------------------------------------------------------------------------
module space_time_reservation_table_core_tb;
	import strt_pkg::*;

	localparam int              SLOTS        = 64;
	localparam logic [CMD_W-1:0] CMD_UNUSED  = 2'd3;
	localparam int              RANDOM_ITEMS = 530;
	localparam int              DRAIN_CYCLES = SLOTS + 40;
	localparam int              LONG_HOLD    = 300;
	localparam int              FIRST_HOLD   = 30;
	localparam int              SECOND_HOLD  = 300;

	typedef struct {
		logic [TIME_W-1:0]   t;
		logic [LOC_IN_W-1:0] loc;
		logic [AGENT_W-1:0]  agent;
	} booking_t;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   s_tvalid = 1'b0;
	logic                   s_tready;
	logic [IN_TDATA_W-1:0]  s_tdata = '0;
	logic                   m_tvalid;
	logic                   m_tready = 1'b0;
	logic [OUT_TDATA_W-1:0] m_tdata;
	int                     fail_count;
	int                     outstanding;

	int       accepted_items = 0;
	int       burst_left = 8;
	booking_t booked[$];

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	space_time_reservation_table_core #(
		.TABLE_ENTRIES(SLOTS),
		.LOCATION_BITS(LOC_IN_W)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata)
	);

	reservation_checker #(
		.TABLE_SLOTS(SLOTS)
	) u_check (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.fail_count(fail_count),
		.outstanding(outstanding)
	);

	// offer one command word, hold until taken, then maybe end the burst
	task automatic offer(input logic [CMD_W-1:0] cmd, input logic [TIME_W-1:0] t,
			input logic [LOC_IN_W-1:0] loc, input logic [AGENT_W-1:0] agent);
		int       gap;
		booking_t entry;
		s_tdata  <= {6'd0, agent, loc, t, cmd};
		s_tvalid <= 1'b1;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		accepted_items++;
		if (cmd == CMD_RESERVE && booked.size() < SLOTS) begin
			entry.t     = t;
			entry.loc   = loc;
			entry.agent = agent;
			booked.insert(booked.size(), entry);
		end
		burst_left--;
		if (burst_left <= 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 9);
			if (gap > 0) begin
				s_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 24);
		end
	endtask

	// narrow ranges much of the time so reservations collide
	function automatic logic [TIME_W-1:0] pick_time();
		return ($urandom_range(0, 9) < 7) ? TIME_W'($urandom_range(0, 7)) : TIME_W'($urandom());
	endfunction

	function automatic logic [AGENT_W-1:0] pick_agent();
		return ($urandom_range(0, 9) < 7) ? AGENT_W'($urandom_range(0, 5)) : AGENT_W'($urandom());
	endfunction

	function automatic logic [LOC_IN_W-1:0] pick_loc();
		return ($urandom_range(0, 1) == 0) ? LOC_IN_W'($urandom_range(0, 7)) : $urandom();
	endfunction

	initial begin
		int                  n;
		int                  roll;
		int                  idx;
		logic [TIME_W-1:0]   t;
		logic [LOC_IN_W-1:0] loc;
		logic [AGENT_W-1:0]  agent;

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty table and the unused code
		offer(CMD_QUERY, 16'h0000, 32'h0000_0000, 8'h00);
		offer(CMD_UPDATE, 16'hFFFF, 32'hFFFF_FFFF, 8'hFF);
		offer(CMD_UNUSED, 16'hFFFF, 32'hFFFF_FFFF, 8'hFF);
		// field extremes, then a duplicate pair
		offer(CMD_RESERVE, 16'h0000, 32'h0000_0000, 8'h00);
		offer(CMD_RESERVE, 16'hFFFF, 32'hFFFF_FFFF, 8'hFF);
		offer(CMD_RESERVE, 16'h0005, 32'h0000_1234, 8'h01);
		offer(CMD_RESERVE, 16'h0005, 32'h0000_1234, 8'h01);
		offer(CMD_RESERVE, 16'h0005, 32'hAAAA_5555, 8'h02);
		// asker alone holds it, another holds it, empty time step
		offer(CMD_QUERY, 16'h0005, 32'h0000_1234, 8'h01);
		offer(CMD_QUERY, 16'h0005, 32'h0000_1234, 8'h03);
		offer(CMD_QUERY, 16'hFFFF, 32'hFFFF_FFFF, 8'h00);
		offer(CMD_QUERY, 16'hFFFF, 32'hFFFF_FFFF, 8'hFF);
		offer(CMD_QUERY, 16'h0006, 32'h0000_1234, 8'h03);
		// two matches: only the earliest moves, the duplicate stays put
		offer(CMD_UPDATE, 16'h0005, 32'h0000_9999, 8'h01);
		offer(CMD_QUERY, 16'h0005, 32'h0000_1234, 8'h03);
		offer(CMD_QUERY, 16'h0005, 32'h0000_9999, 8'h02);
		offer(CMD_UPDATE, 16'h0005, 32'h0000_7777, 8'h01);
		offer(CMD_QUERY, 16'h0005, 32'h0000_9999, 8'h02);
		offer(CMD_QUERY, 16'h0005, 32'h0000_7777, 8'h02);
		offer(CMD_UPDATE, 16'h0007, 32'h0000_4444, 8'h01);
		offer(CMD_UNUSED, 16'h0000, 32'h0000_0000, 8'h00);

		// random traffic; reserves past the table size exercise the full flag
		for (n = 0; n < RANDOM_ITEMS; n++) begin
			roll  = $urandom_range(0, 99);
			t     = pick_time();
			loc   = pick_loc();
			agent = pick_agent();
			if (roll < 30) begin
				offer(CMD_RESERVE, t, loc, agent);
			end else if (roll < 70) begin
				if (booked.size() > 0 && $urandom_range(0, 9) < 7) begin
					idx = $urandom_range(0, booked.size() - 1);
					t = booked[idx].t;
					if ($urandom_range(0, 9) < 8)
						loc = booked[idx].loc;
					if ($urandom_range(0, 1) == 0)
						agent = booked[idx].agent;
				end
				offer(CMD_QUERY, t, loc, agent);
			end else if (roll < 95) begin
				if (booked.size() > 0 && $urandom_range(0, 3) != 0) begin
					idx = $urandom_range(0, booked.size() - 1);
					t = booked[idx].t;
					agent = booked[idx].agent;
					booked[idx].loc = loc;
				end
				offer(CMD_UPDATE, t, loc, agent);
			end else begin
				offer(CMD_UNUSED, t, loc, agent);
			end
		end
		s_tvalid <= 1'b0;

		@(posedge clk);
		while (outstanding != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_count == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

	// output side: stall pattern changes after each random span; two long
	// holds back the block up into its input
	initial begin
		int mode;
		int span;
		int phase;
		int holds_done;
		holds_done = 0;
		phase = 0;
		forever begin
			mode = $urandom_range(0, 3);
			span = $urandom_range(16, 96);
			repeat (span) begin
				@(posedge clk);
				if ((holds_done == 0 && accepted_items >= FIRST_HOLD) ||
						(holds_done == 1 && accepted_items >= SECOND_HOLD)) begin
					m_tready <= 1'b0;
					repeat (LONG_HOLD) @(posedge clk);
					holds_done++;
				end
				phase++;
				case (mode)
					0: m_tready <= 1'b1;
					1: m_tready <= ($urandom_range(0, 1) == 1);
					2: m_tready <= ($urandom_range(0, 4) == 0);
					default: m_tready <= (phase % 3 != 0);
				endcase
			end
		end
	end

	initial begin
		#2_000_000;
		$display("[FAIL] regression broken");
		$finish;
	end

endmodule
